// ----- rtl/a4b_pkg.sv -----
// ----------------------------------------------------------------------------
// a4b_pkg
// Shared types and constants for the ARGB4444 alpha blender.
// ----------------------------------------------------------------------------
package a4b_pkg;

	localparam int NIB_W   = 4;
	localparam int PIX_W   = 16;
	localparam int RECIP_W = 16;

	localparam logic [NIB_W-1:0] ALPHA_OPAQUE = 4'hf;
	localparam logic [NIB_W-1:0] ALPHA_CLEAR  = 4'h0;

	typedef enum logic [1:0] {
		CASE_SRC,
		CASE_DST,
		CASE_OPQ,
		CASE_MIX
	} blend_case_t;

	// ceil(2^16 / sum); exact floor(n / sum) for n * err < 2^16, n <= 210
	function automatic logic [RECIP_W-1:0] recip(input logic [4:0] sum);
		logic [RECIP_W-1:0] r;
		case (sum)
			5'd2:    r = 16'd32768;
			5'd3:    r = 16'd21846;
			5'd4:    r = 16'd16384;
			5'd5:    r = 16'd13108;
			5'd6:    r = 16'd10923;
			5'd7:    r = 16'd9363;
			5'd8:    r = 16'd8192;
			5'd9:    r = 16'd7282;
			5'd10:   r = 16'd6554;
			5'd11:   r = 16'd5958;
			5'd12:   r = 16'd5462;
			5'd13:   r = 16'd5042;
			5'd14:   r = 16'd4682;
			5'd15:   r = 16'd4370;
			5'd16:   r = 16'd4096;
			5'd17:   r = 16'd3856;
			5'd18:   r = 16'd3641;
			5'd19:   r = 16'd3450;
			5'd20:   r = 16'd3277;
			5'd21:   r = 16'd3121;
			5'd22:   r = 16'd2979;
			5'd23:   r = 16'd2850;
			5'd24:   r = 16'd2731;
			5'd25:   r = 16'd2622;
			5'd26:   r = 16'd2521;
			5'd27:   r = 16'd2428;
			5'd28:   r = 16'd2341;
			5'd29:   r = 16'd2260;
			5'd30:   r = 16'd2185;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage

// ----- rtl/a4b_chan.sv -----
// ----------------------------------------------------------------------------
// a4b_chan
// One color channel: weighted products, then reciprocal-multiply divide (mix) and divide by 16 (opaque destination).
// ----------------------------------------------------------------------------
module a4b_chan (
	input  logic                       clk,
	input  logic                       en,
	input  logic [a4b_pkg::NIB_W-1:0]  s,
	input  logic [a4b_pkg::NIB_W-1:0]  d,
	input  logic [a4b_pkg::NIB_W-1:0]  sa,
	input  logic [a4b_pkg::NIB_W-1:0]  da,
	input  logic [a4b_pkg::RECIP_W-1:0] recip_s2,
	output logic [a4b_pkg::NIB_W-1:0]  mix_s3,
	output logic [a4b_pkg::NIB_W-1:0]  opq_s3
);
	import a4b_pkg::*;

	logic [7:0] ps_mix_s2, pd_mix_s2, ps_opq_s2, pd_opq_s2;
	logic [23:0] qs, qd;
	logic [4:0] sa_p1, sa_inv;

	assign sa_p1  = {1'b0, sa} + 5'd1;
	assign sa_inv = 5'd16 - {1'b0, sa};

	always_ff @(posedge clk) begin
		if (en) begin
			ps_mix_s2 <= s * sa;
			pd_mix_s2 <= d * da;
			ps_opq_s2 <= 8'(s * sa_p1);
			pd_opq_s2 <= 8'(d * sa_inv);
		end
	end

	assign qs = ps_mix_s2 * recip_s2;
	assign qd = pd_mix_s2 * recip_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			mix_s3 <= qs[19:16] + qd[19:16];
			opq_s3 <= ps_opq_s2[7:4] + pd_opq_s2[7:4];
		end
	end

endmodule

// ----- rtl/argb4444_alpha_blend.sv -----
// ----------------------------------------------------------------------------
// argb4444_alpha_blend
// ARGB4444 source-over-destination blender with a 4-bit opacity level.
//
// Input stream s_axis: one transaction carries destination pixel, source
// pixel and blend level. Output stream m_axis: one blended pixel for each
// input transaction, in order.
// Stages, in order: alpha scale, case select and products, reciprocal multiply,
// final select register. Throughput: one pixel per cycle unless the output
// stalls; the divide by (da + sa) is a table reciprocal and a 8x16 multiply,
// so every stage is fully pipelined.
// Reset: all valid bits clear; payload registers are not reset.
// Stall: when m_axis_tready is low with a valid output, the whole pipeline
// holds and s_axis_tready drops; nothing is dropped or repeated. All stages
// move together, so bubbles inside the pipeline are not squeezed out.
// ----------------------------------------------------------------------------
module argb4444_alpha_blend (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [15:0] dest_pixel, [31:16] source_pixel, [35:32] blend_level, [39:36] zero
	input  logic [39:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] blended_pixel
	output logic [15:0] m_axis_tdata
);
	import a4b_pkg::*;

	logic en;

	logic                v_s1, v_s2, v_s3;
	logic [PIX_W-1:0]    src_s1, dst_s1;
	logic [NIB_W-1:0]    sa_s1;
	logic [7:0]          sa_prod;

	logic [NIB_W-1:0]    da_s1;
	logic [4:0]          sum_s1;
	blend_case_t         case_s1;
	logic [NIB_W-1:0]    alpha_s1;

	blend_case_t         case_s2, case_s3;
	logic [NIB_W-1:0]    alpha_s2, alpha_s3;
	logic [11:0]         src_s2, src_s3;
	logic [PIX_W-1:0]    dst_s2, dst_s3;
	logic [RECIP_W-1:0]  recip_s2;

	logic [11:0]         mix_s3, opq_s3;
	logic [PIX_W-1:0]    pix_s3;

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// stage 1: register inputs, scale source alpha
	assign sa_prod = 8'(s_axis_tdata[31:28] * ({1'b0, s_axis_tdata[35:32]} + 5'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			v_s1          <= s_axis_tvalid;
			v_s2          <= v_s1;
			v_s3          <= v_s2;
			m_axis_tvalid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dst_s1 <= s_axis_tdata[15:0];
			src_s1 <= s_axis_tdata[31:16];
			sa_s1  <= sa_prod[7:4];
		end
	end

	// stage 2: case select, divisor reciprocal
	assign da_s1  = dst_s1[15:12];
	assign sum_s1 = {1'b0, da_s1} + {1'b0, sa_s1};

	always_comb begin
		if (sa_s1 == ALPHA_OPAQUE) begin
			case_s1  = CASE_SRC;
			alpha_s1 = sa_s1;
		end else if (sa_s1 == ALPHA_CLEAR) begin
			case_s1  = CASE_DST;
			alpha_s1 = da_s1;
		end else if (da_s1 == ALPHA_CLEAR) begin
			case_s1  = CASE_SRC;
			alpha_s1 = sa_s1;
		end else if (da_s1 == ALPHA_OPAQUE) begin
			case_s1  = CASE_OPQ;
			alpha_s1 = ALPHA_OPAQUE;
		end else begin
			case_s1  = CASE_MIX;
			alpha_s1 = (da_s1 > sa_s1) ? da_s1 : sa_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			case_s2  <= case_s1;
			alpha_s2 <= alpha_s1;
			src_s2   <= src_s1[11:0];
			dst_s2   <= dst_s1;
			recip_s2 <= recip(sum_s1);
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_chan
		a4b_chan u_chan (
			.clk      (clk),
			.en       (en),
			.s        (src_s1[ch*NIB_W +: NIB_W]),
			.d        (dst_s1[ch*NIB_W +: NIB_W]),
			.sa       (sa_s1),
			.da       (da_s1),
			.recip_s2 (recip_s2),
			.mix_s3   (mix_s3[ch*NIB_W +: NIB_W]),
			.opq_s3   (opq_s3[ch*NIB_W +: NIB_W])
		);
	end

	// stage 3: carry case info beside the channel quotients
	always_ff @(posedge clk) begin
		if (en) begin
			case_s3  <= case_s2;
			alpha_s3 <= alpha_s2;
			src_s3   <= src_s2;
			dst_s3   <= dst_s2;
		end
	end

	// stage 4: final select into the output register
	always_comb begin
		case (case_s3)
			CASE_SRC: pix_s3 = {alpha_s3, src_s3};
			CASE_DST: pix_s3 = dst_s3;
			CASE_OPQ: pix_s3 = {ALPHA_OPAQUE, opq_s3};
			CASE_MIX: pix_s3 = {alpha_s3, mix_s3};
			default:  pix_s3 = dst_s3;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= pix_s3;
		end
	end

	a_valid_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && en) |=> m_axis_tvalid)
		else $error("stage 3 transaction did not reach output");

	a_opaque_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s3 && case_s3 == CASE_OPQ) |=> (m_axis_tdata[15:12] == ALPHA_OPAQUE))
		else $error("opaque destination blend lost full alpha");

	a_dst_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s3 && case_s3 == CASE_DST) |=> (m_axis_tdata == $past(dst_s3)))
		else $error("invisible source altered destination");

	a_full_src: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s1 && sa_s1 == ALPHA_OPAQUE) |=> (case_s2 == CASE_SRC))
		else $error("opaque scaled source not selected");

endmodule
